/* src/ssvm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the raised-cosine weight table of the spherical mask unit.
package ssvm_pkg;

    // Design limits
    localparam int MAX_DIM   = 64;
    localparam int COS_STEPS = 256;

    // Field and register widths
    localparam int VAL_W      = 32;
    localparam int SIZE_W     = 7;
    localparam int NOM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [NOM_W-1:0]  NOM_RESET  = 11'd64;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_Z = 3'd5;

    // Item commands
    localparam logic CMD_AVERAGE = 1'b0;
    localparam logic CMD_MASK    = 1'b1;

    // Geometry
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int EXT_W   = $clog2(MAX_DIM + 1);
    localparam int D_W     = POS_W + 1;
    localparam int R2_W    = 2 * D_W;
    localparam int RQ_FRAC = 8;
    localparam int RAD_W   = R2_W + 2 * RQ_FRAC;
    localparam int ROOT_W  = RAD_W / 2;

    // Shell accumulation and the mean divide
    localparam int SUM_W   = 51;
    localparam int COUNT_W = 19;
    localparam int DIV_W   = SUM_W - 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Shared shift/subtract unit
    localparam int SRC_W  = DIV_W;
    localparam int REM_W  = (ROOT_W + 4 > COUNT_W + 2) ? ROOT_W + 4 : COUNT_W + 2;
    localparam int STEP_W = $clog2(SRC_W);

    // Radii: r0 = floor(sum/6) - 4, r1 = r0 - 4, both scaled by 2^RQ_FRAC
    localparam int NOMSUM_W    = NOM_W + 2;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] DIV6_RECIP = 14'd10923;
    localparam int RADIUS_STEP = 4;
    localparam int R0_W        = NOM_W + 1;
    localparam int R_W         = (ROOT_W + 1 > NOM_W + RQ_FRAC + 1) ?
                                 ROOT_W + 1 : NOM_W + RQ_FRAC + 1;
    localparam int EDGE_Q      = RADIUS_STEP << RQ_FRAC;
    localparam int EDGE_W      = $clog2(EDGE_Q);

    // Weight lookup and blend
    localparam int IDX_W     = $clog2(COS_STEPS);
    localparam int IPROD_W   = EDGE_W + $clog2(COS_STEPS + 1);
    localparam int W_W       = 17;
    localparam int W_SHIFT   = 16;
    localparam int PROD_W    = (VAL_W + 1) + (W_W + 1);
    localparam int BSUM_W    = PROD_W + 1;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259369;

    typedef logic [W_W-1:0] weight_tab_t [COS_STEPS];

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [NOM_W-1:0]  nominal_x;
        logic [NOM_W-1:0]  nominal_y;
        logic [NOM_W-1:0]  nominal_z;
    } ssvm_cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic classify;
        logic accum;
        logic set_empty;
        logic start_div;
        logic store_mean;
        logic mul;
        logic emit;
    } ssvm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic iter_done;
        logic item_cmd;
        logic item_last;
        logic count_zero;
        logic out_free;
    } ssvm_stat_t;

    // Size clamped into [1, MAX_DIM]
    function automatic logic [EXT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [EXT_W-1:0] r;
        if (s == '0) begin
            r = EXT_W'(1);
        end else if (int'(s) > MAX_DIM) begin
            r = EXT_W'(MAX_DIM);
        end else begin
            r = EXT_W'(s);
        end
        return r;
    endfunction

    // cos(a) in Q30 for a in [0, pi/2], Taylor series in nested form
    function automatic longint cos_q30(input longint a);
        longint a2;
        longint inner;
        longint p;
        longint c;
        a2 = (a * a) >>> 30;
        inner = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            p = (a2 * inner) >>> 30;
            case (i)
                0: p = p / 132;
                1: p = p / 90;
                2: p = p / 56;
                3: p = p / 30;
                default: p = p / 12;
            endcase
            inner = Q30_ONE - p;
            if (inner < 0) inner = 0;
        end
        p = (a2 * inner) >>> 30;
        c = Q30_ONE - p / 2;
        if (c < 0) c = 0;
        if (c > Q30_ONE) c = Q30_ONE;
        return c;
    endfunction

    // w[i] = round(65536 * (1 + cos(pi * i / COS_STEPS)) / 2)
    function automatic weight_tab_t build_weights();
        weight_tab_t tab;
        longint c;
        for (int i = 0; i < COS_STEPS; i++) begin
            if (2 * i <= COS_STEPS) begin
                c = cos_q30((PI_Q30 * longint'(i)) / COS_STEPS);
            end else begin
                c = -cos_q30((PI_Q30 * longint'(COS_STEPS - i)) / COS_STEPS);
            end
            tab[i] = W_W'((Q30_ONE + c + 64'sd16384) >>> 15);
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

/* src/ssvm_iter.sv */
`timescale 1ns / 1ps
// Shared shift/subtract unit: one root bit or one quotient bit per cycle.
module ssvm_iter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_sqrt,
    input  logic                          start_div,
    input  logic [ssvm_pkg::SRC_W-1:0]    operand,   // radicand top-aligned, or dividend
    input  logic [ssvm_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [ssvm_pkg::SRC_W-1:0]    result
);

    logic                          busy_reg;
    logic                          is_div_reg;
    logic [ssvm_pkg::STEP_W-1:0]   step_reg;
    logic [ssvm_pkg::SRC_W-1:0]    src_reg;
    logic [ssvm_pkg::REM_W-1:0]    rem_reg;
    logic [ssvm_pkg::SRC_W-1:0]    acc_reg;
    logic [ssvm_pkg::COUNT_W-1:0]  dsr_reg;

    logic [ssvm_pkg::REM_W-1:0]    rem_sh;
    logic [ssvm_pkg::REM_W-1:0]    trial;
    logic [ssvm_pkg::REM_W-1:0]    rem_diff;
    logic                          ge;

    always_comb begin
        if (is_div_reg) begin
            rem_sh = {rem_reg[ssvm_pkg::REM_W-2:0], src_reg[ssvm_pkg::SRC_W-1]};
            trial  = ssvm_pkg::REM_W'(dsr_reg);
        end else begin
            rem_sh = {rem_reg[ssvm_pkg::REM_W-3:0], src_reg[ssvm_pkg::SRC_W-1 -: 2]};
            trial  = {acc_reg[ssvm_pkg::REM_W-3:0], 2'b01};
        end
        ge       = (rem_sh >= trial);
        rem_diff = rem_sh - trial;
    end

    assign done   = busy_reg && (step_reg == '0);
    assign result = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start_sqrt || start_div) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_sqrt || start_div) begin
            src_reg    <= operand;
            rem_reg    <= '0;
            acc_reg    <= '0;
            dsr_reg    <= divisor;
            is_div_reg <= start_div;
            step_reg   <= start_div ? ssvm_pkg::STEP_W'(ssvm_pkg::SRC_W - 1)
                                    : ssvm_pkg::STEP_W'(ssvm_pkg::ROOT_W - 1);
        end else if (busy_reg) begin
            src_reg  <= is_div_reg ? (src_reg << 1) : (src_reg << 2);
            rem_reg  <= ge ? rem_diff : rem_sh;
            acc_reg  <= {acc_reg[ssvm_pkg::SRC_W-2:0], ge};
            step_reg <= step_reg - ssvm_pkg::STEP_W'(1);
        end
    end

endmodule

/* src/ssvm_dpath.sv */
`timescale 1ns / 1ps
// Datapath: voxel position, distance, shell sums, mean, blend and the output register.
module ssvm_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ssvm_pkg::ssvm_cfg_t          cfg,
    input  ssvm_pkg::ssvm_cmd_t          cmd,
    output ssvm_pkg::ssvm_stat_t         stat,
    input  logic [ssvm_pkg::VAL_W-1:0]   s_tdata,
    input  logic [0:0]                   s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ssvm_pkg::VAL_W-1:0]   m_tdata,
    output logic [0:0]                   m_tuser,
    output logic                         m_tlast
);

    // Position and geometry
    logic [ssvm_pkg::POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg;
    logic [ssvm_pkg::EXT_W-1:0]  ex, ey, ez;
    logic signed [ssvm_pkg::D_W-1:0]  dx, dy, dz;
    logic signed [ssvm_pkg::R2_W-1:0] sq_x, sq_y, sq_z;
    logic [ssvm_pkg::R2_W-1:0]   r2;
    logic [ssvm_pkg::POS_W:0]    inc_x, inc_y, inc_z;
    logic                        wrap_x, wrap_y, wrap_z;

    // Current item
    logic                               item_cmd_reg;
    logic                               item_last_reg;
    logic signed [ssvm_pkg::VAL_W-1:0]  item_val_reg;

    // Radii
    logic [ssvm_pkg::NOMSUM_W-1:0]                  nom_sum;
    logic [ssvm_pkg::NOMSUM_W+ssvm_pkg::RECIP_W-1:0] nom_prod;
    logic signed [ssvm_pkg::R0_W-1:0]               r0;
    logic signed [ssvm_pkg::R_W-1:0]                r0q_reg, r1q_reg;

    // Shell state
    logic signed [ssvm_pkg::SUM_W-1:0]  sum_reg;
    logic [ssvm_pkg::COUNT_W-1:0]       count_reg;
    logic signed [ssvm_pkg::VAL_W-1:0]  mean_reg;
    logic                               empty_reg;
    logic signed [ssvm_pkg::SUM_W-1:0]  sum_mag;
    logic [ssvm_pkg::VAL_W-1:0]         quo;

    // Shared unit
    logic                        iter_done;
    logic [ssvm_pkg::SRC_W-1:0]  iter_operand;
    logic [ssvm_pkg::SRC_W-1:0]  iter_result;

    // Classification and weight
    logic signed [ssvm_pkg::R_W-1:0]              rq;
    logic signed [ssvm_pkg::R_W-1:0]              edge_q;
    logic [ssvm_pkg::IPROD_W-1:0]                 iprod;
    logic [ssvm_pkg::IPROD_W-ssvm_pkg::EDGE_W-1:0] idx_full;
    logic [ssvm_pkg::IDX_W-1:0]                   idx;
    logic                                         in_shell_reg, band_reg, beyond_reg;
    logic [ssvm_pkg::W_W-1:0]                     w_reg;

    // Blend
    logic signed [ssvm_pkg::VAL_W:0]     vdiff;
    logic signed [ssvm_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ssvm_pkg::BSUM_W-1:0]  bsum;
    logic signed [ssvm_pkg::BSUM_W-1:0]  bres;
    logic signed [ssvm_pkg::VAL_W-1:0]   blend_sat;
    logic signed [ssvm_pkg::VAL_W-1:0]   res;

    // Output register
    logic                        m_tvalid_reg;
    logic [ssvm_pkg::VAL_W-1:0]  m_tdata_reg;
    logic                        m_tlast_reg;
    logic                        m_tuser_reg;

    // ---------------- distance of the current position ----------------
    always_comb begin
        ex = ssvm_pkg::eff_size(cfg.size_x);
        ey = ssvm_pkg::eff_size(cfg.size_y);
        ez = ssvm_pkg::eff_size(cfg.size_z);
        dx = $signed({1'b0, pos_x_reg}) - $signed(ssvm_pkg::D_W'(ex[ssvm_pkg::EXT_W-1:1]));
        dy = $signed({1'b0, pos_y_reg}) - $signed(ssvm_pkg::D_W'(ey[ssvm_pkg::EXT_W-1:1]));
        dz = $signed({1'b0, pos_z_reg}) - $signed(ssvm_pkg::D_W'(ez[ssvm_pkg::EXT_W-1:1]));
        sq_x = dx * dx;
        sq_y = dy * dy;
        sq_z = dz * dz;
        r2 = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

        inc_x  = {1'b0, pos_x_reg} + (ssvm_pkg::POS_W+1)'(1);
        inc_y  = {1'b0, pos_y_reg} + (ssvm_pkg::POS_W+1)'(1);
        inc_z  = {1'b0, pos_z_reg} + (ssvm_pkg::POS_W+1)'(1);
        wrap_x = inc_x >= (ssvm_pkg::POS_W+1)'(ex);
        wrap_y = inc_y >= (ssvm_pkg::POS_W+1)'(ey);
        wrap_z = inc_z >= (ssvm_pkg::POS_W+1)'(ez);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end else if (cmd.load_item) begin
            if (s_tlast) begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                pos_z_reg <= '0;
            end else if (!wrap_z) begin
                pos_z_reg <= inc_z[ssvm_pkg::POS_W-1:0];
            end else begin
                pos_z_reg <= '0;
                if (!wrap_y) begin
                    pos_y_reg <= inc_y[ssvm_pkg::POS_W-1:0];
                end else begin
                    pos_y_reg <= '0;
                    pos_x_reg <= wrap_x ? '0 : inc_x[ssvm_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_cmd_reg  <= s_tuser[0];
            item_last_reg <= s_tlast;
            item_val_reg  <= $signed(s_tdata);
        end
    end

    // ---------------- radii, refreshed every cycle from config ----------------
    always_comb begin
        nom_sum  = ssvm_pkg::NOMSUM_W'(cfg.nominal_x) + ssvm_pkg::NOMSUM_W'(cfg.nominal_y)
                 + ssvm_pkg::NOMSUM_W'(cfg.nominal_z);
        nom_prod = (ssvm_pkg::NOMSUM_W+ssvm_pkg::RECIP_W)'(nom_sum) * ssvm_pkg::DIV6_RECIP;
        r0 = $signed(ssvm_pkg::R0_W'(nom_prod >> ssvm_pkg::RECIP_SHIFT))
           - ssvm_pkg::R0_W'(ssvm_pkg::RADIUS_STEP);
    end

    always_ff @(posedge aclk) begin
        r0q_reg <= ssvm_pkg::R_W'(r0) <<< ssvm_pkg::RQ_FRAC;
        r1q_reg <= (ssvm_pkg::R_W'(r0) <<< ssvm_pkg::RQ_FRAC) - ssvm_pkg::R_W'(ssvm_pkg::EDGE_Q);
    end

    // ---------------- shared square root / divide ----------------
    always_comb begin
        sum_mag = sum_reg[ssvm_pkg::SUM_W-1] ? -sum_reg : sum_reg;
        if (cmd.start_div) begin
            iter_operand = sum_mag[ssvm_pkg::DIV_W-1:0];
        end else begin
            iter_operand = {r2, {(ssvm_pkg::SRC_W-ssvm_pkg::R2_W){1'b0}}};
        end
    end

    ssvm_iter u_iter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_sqrt (cmd.load_item),
        .start_div  (cmd.start_div),
        .operand    (iter_operand),
        .divisor    (count_reg),
        .done       (iter_done),
        .result     (iter_result)
    );

    // ---------------- classification and weight lookup ----------------
    always_comb begin
        rq       = $signed(ssvm_pkg::R_W'(iter_result[ssvm_pkg::ROOT_W-1:0]));
        edge_q   = rq - r1q_reg;
        iprod    = ssvm_pkg::IPROD_W'(edge_q[ssvm_pkg::EDGE_W-1:0])
                 * ssvm_pkg::IPROD_W'(ssvm_pkg::COS_STEPS);
        idx_full = iprod[ssvm_pkg::IPROD_W-1:ssvm_pkg::EDGE_W];
        if (idx_full >= (ssvm_pkg::IPROD_W-ssvm_pkg::EDGE_W)'(ssvm_pkg::COS_STEPS)) begin
            idx = ssvm_pkg::IDX_W'(ssvm_pkg::COS_STEPS - 1);
        end else begin
            idx = idx_full[ssvm_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.classify) begin
            in_shell_reg <= (rq >= r1q_reg) && (rq <= r0q_reg);
            band_reg     <= (rq >= r1q_reg) && (rq < r0q_reg);
            beyond_reg   <= (rq >= r0q_reg);
            w_reg        <= ssvm_pkg::WEIGHT_TAB[idx];
        end
    end

    // ---------------- shell sum, count and mean ----------------
    assign quo = iter_result[ssvm_pkg::VAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            mean_reg  <= '0;
            empty_reg <= 1'b0;
        end else if (cmd.accum) begin
            if (in_shell_reg && (count_reg != ssvm_pkg::COUNT_MAX)) begin
                sum_reg   <= sum_reg + ssvm_pkg::SUM_W'(item_val_reg);
                count_reg <= count_reg + ssvm_pkg::COUNT_W'(1);
            end
        end else if (cmd.set_empty) begin
            mean_reg  <= '0;
            empty_reg <= 1'b1;
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.store_mean) begin
            mean_reg  <= sum_reg[ssvm_pkg::SUM_W-1] ? $signed(-quo) : $signed(quo);
            empty_reg <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
    end

    // ---------------- blend: (v - mean) * w + mean * 2^16, rounded ----------------
    assign vdiff = $signed({item_val_reg[ssvm_pkg::VAL_W-1], item_val_reg})
                 - $signed({mean_reg[ssvm_pkg::VAL_W-1], mean_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= vdiff * $signed({1'b0, w_reg});
        end
    end

    always_comb begin
        bsum = ssvm_pkg::BSUM_W'(prod_reg)
             + (ssvm_pkg::BSUM_W'(mean_reg) <<< ssvm_pkg::W_SHIFT)
             + ssvm_pkg::BSUM_W'(1 << (ssvm_pkg::W_SHIFT - 1));
        bres = bsum >>> ssvm_pkg::W_SHIFT;
        if (&bres[ssvm_pkg::BSUM_W-1:ssvm_pkg::VAL_W-1]
            || ~|bres[ssvm_pkg::BSUM_W-1:ssvm_pkg::VAL_W-1]) begin
            blend_sat = bres[ssvm_pkg::VAL_W-1:0];
        end else if (bres[ssvm_pkg::BSUM_W-1]) begin
            blend_sat = {1'b1, {(ssvm_pkg::VAL_W-1){1'b0}}};
        end else begin
            blend_sat = {1'b0, {(ssvm_pkg::VAL_W-1){1'b1}}};
        end

        if (band_reg) begin
            res = blend_sat;
        end else if (beyond_reg) begin
            res = mean_reg;
        end else begin
            res = item_val_reg;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= res;
            m_tlast_reg <= item_last_reg;
            m_tuser_reg <= empty_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    always_comb begin
        stat.iter_done  = iter_done;
        stat.item_cmd   = item_cmd_reg;
        stat.item_last  = item_last_reg;
        stat.count_zero = (count_reg == '0);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

/* src/ssvm_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one item at a time through root, classify, then accumulate or blend, and the mean divide.
module ssvm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ssvm_pkg::ssvm_stat_t  stat,
    output ssvm_pkg::ssvm_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_CLASS,
        S_ACCUM,
        S_END,
        S_DIV,
        S_MEAN,
        S_MUL,
        S_BLEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (stat.iter_done) state_next = S_CLASS;
            end
            S_CLASS: begin
                cmd.classify = 1'b1;
                state_next   = (stat.item_cmd == ssvm_pkg::CMD_MASK) ? S_MUL : S_ACCUM;
            end
            S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = stat.item_last ? S_END : S_IDLE;
            end
            S_END: begin
                if (stat.count_zero) begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.iter_done) state_next = S_MEAN;
            end
            S_MEAN: begin
                cmd.store_mean = 1'b1;
                state_next     = S_IDLE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_BLEND;
            end
            S_BLEND: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

/* src/soft_spherical_volume_mask_unit.sv */
`timescale 1ns / 1ps
// Top level of the soft spherical volume mask: config registers, controller and datapath.
//
// The volume is streamed twice, z fastest, then y, then x. A beat with tuser = 0 belongs
// to the averaging pass: voxels whose center distance r lies in [r1, r0] are summed, and
// at the tlast beat the sum is divided by the count to form the shell mean (an empty shell
// gives a mean of zero and raises the empty flag). A beat with tuser = 1 belongs to the
// masking pass and yields one output beat: the voxel as is inside r1, a raised-cosine blend
// of voxel and mean between r1 and r0, and the mean beyond r0. r0 = floor((nominal_x +
// nominal_y + nominal_z) / 6) - 4 and r1 = r0 - 4. Voxels are signed Q16.16; r carries 8
// fraction bits. Items are handled one at a time. The distance square root runs on a shared
// shift/subtract unit at one root bit per cycle, and a masking beat waits until the output
// register is free. The tlast beat of an averaging pass also runs the 50-bit mean divide
// on the same unit. A finished result sits in the output register while the next beat is
// accepted. Config writes are always taken, but must only be issued while no beat is in
// flight.
module soft_spherical_volume_mask_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ssvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssvm_pkg::CFG_DATA_W-1:0]   cfg_data,

    // Voxel input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssvm_pkg::VAL_W-1:0]        s_tdata,   // [31:0] voxel_value
    input  logic [0:0]                        s_tuser,   // [0] cmd
    input  logic                              s_tlast,

    // Masked output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssvm_pkg::VAL_W-1:0]        m_tdata,   // [31:0] masked_value
    output logic [0:0]                        m_tuser,   // [0] empty_shell
    output logic                              m_tlast
);

    logic [ssvm_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [ssvm_pkg::NOM_W-1:0]  nominal_x_reg, nominal_y_reg, nominal_z_reg;

    ssvm_pkg::ssvm_cfg_t  cfg;
    ssvm_pkg::ssvm_cmd_t  cmd;
    ssvm_pkg::ssvm_stat_t stat;

    // Register file: writes are never back-pressured; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg    <= ssvm_pkg::SIZE_RESET;
            size_y_reg    <= ssvm_pkg::SIZE_RESET;
            size_z_reg    <= ssvm_pkg::SIZE_RESET;
            nominal_x_reg <= ssvm_pkg::NOM_RESET;
            nominal_y_reg <= ssvm_pkg::NOM_RESET;
            nominal_z_reg <= ssvm_pkg::NOM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ssvm_pkg::CFG_SIZE_X:    size_x_reg    <= cfg_data[ssvm_pkg::SIZE_W-1:0];
                ssvm_pkg::CFG_SIZE_Y:    size_y_reg    <= cfg_data[ssvm_pkg::SIZE_W-1:0];
                ssvm_pkg::CFG_SIZE_Z:    size_z_reg    <= cfg_data[ssvm_pkg::SIZE_W-1:0];
                ssvm_pkg::CFG_NOMINAL_X: nominal_x_reg <= cfg_data[ssvm_pkg::NOM_W-1:0];
                ssvm_pkg::CFG_NOMINAL_Y: nominal_y_reg <= cfg_data[ssvm_pkg::NOM_W-1:0];
                ssvm_pkg::CFG_NOMINAL_Z: nominal_z_reg <= cfg_data[ssvm_pkg::NOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.size_x    = size_x_reg;
        cfg.size_y    = size_y_reg;
        cfg.size_z    = size_z_reg;
        cfg.nominal_x = nominal_x_reg;
        cfg.nominal_y = nominal_y_reg;
        cfg.nominal_z = nominal_z_reg;
    end

    // Sequencer: accepts a beat only when idle, then steps the datapath.
    ssvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Position counters, root/divide unit, shell state, blend and output register.
    ssvm_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
